// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the peak estimator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// pre implies post in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// pre implies post in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// File: sv/spfe_pkg.sv
// ----------------------------------------------------------------------------
// spfe_pkg
// Types and constants shared by the spectral peak estimator modules.
// ----------------------------------------------------------------------------
package spfe_pkg;

    // spectrum geometry
    localparam int FFT_POINTS = 4096;
    localparam int BIN_W      = 24;
    localparam int CNT_W      = 12;
    localparam int BIDX_W     = 11;
    localparam logic [CNT_W-1:0] HALF_LAST = CNT_W'(FFT_POINTS / 2 - 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    // datapath widths
    localparam int PWR_W  = 48;
    localparam int MAG_W  = 32;
    localparam int FREQ_W = 20;
    localparam int BW_W   = 24;
    localparam int POS_W  = 28;
    localparam int PROD_W = POS_W + BW_W;
    localparam int Q_W    = 17;
    localparam logic [Q_W-1:0] Q_MAX = 17'd65536;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd2;
    localparam logic [BW_W-1:0]   RST_BIN_WIDTH  = 24'd65536;
    localparam logic [FREQ_W-1:0] RST_LOW_LIMIT  = 20'd2560;
    localparam logic [FREQ_W-1:0] RST_HIGH_LIMIT = 20'd89600;

    // shared compare-subtract unit
    localparam int CSU_SRC_W = 64;
    localparam int CSU_REM_W = 36;
    localparam int CSU_DIV_W = 34;
    localparam int CSU_CNT_W = 6;
    localparam logic [CSU_CNT_W-1:0] CSU_SQRT_STEPS = 6'd32;
    localparam logic [CSU_CNT_W-1:0] CSU_DIV_STEPS  = 6'd17;

    typedef struct packed {
        logic                 start;
        logic                 div_mode;
        logic [CSU_SRC_W-1:0] src;
        logic [CSU_REM_W-1:0] rem_init;
        logic [CSU_DIV_W-1:0] divisor;
    } t_csu_cmd;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] result;
    } t_csu_rsp;

endpackage

// File: sv/spfe_csu.sv
// ----------------------------------------------------------------------------
// spfe_csu
// Iterative compare-subtract unit: digit-by-digit square root (two source
// bits per step) or restoring division (one dividend bit per step).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spfe_csu import spfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_csu_cmd i_cmd,
    output t_csu_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_div_mode;
    logic [CSU_SRC_W-1:0] r_src;
    logic [CSU_REM_W-1:0] r_rem;
    logic [MAG_W-1:0]     r_res;
    logic [CSU_DIV_W-1:0] r_divisor;
    logic [CSU_CNT_W-1:0] r_cnt;

    logic [CSU_REM_W-1:0] w_cand;
    logic [CSU_REM_W-1:0] w_trial;
    logic [CSU_REM_W-1:0] w_diff;
    logic                 w_ge;

    always_comb begin
        if (r_div_mode) begin
            w_cand  = {r_rem[CSU_REM_W-2:0], r_src[CSU_SRC_W-1]};
            w_trial = {2'b00, r_divisor};
        end else begin
            w_cand  = {r_rem[CSU_REM_W-3:0], r_src[CSU_SRC_W-1 -: 2]};
            w_trial = {2'b00, r_res, 2'b01};
        end
        w_ge   = (w_cand >= w_trial);
        w_diff = w_cand - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy     <= 1'b1;
                r_div_mode <= i_cmd.div_mode;
                r_src      <= i_cmd.src;
                r_rem      <= i_cmd.rem_init;
                r_divisor  <= i_cmd.divisor;
                r_res      <= '0;
                r_cnt      <= i_cmd.div_mode ? CSU_DIV_STEPS : CSU_SQRT_STEPS;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff : w_cand;
                r_res <= {r_res[MAG_W-2:0], w_ge};
                r_src <= r_div_mode ? {r_src[CSU_SRC_W-2:0], 1'b0}
                                    : {r_src[CSU_SRC_W-3:0], 2'b00};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CSU_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    `ASSERT_IMPLY(a_csu_no_restart, i_clk, i_rst_n, i_cmd.start, !r_busy)
    `ASSERT_IMPLY(a_csu_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `ASSERT_IMPLY(a_csu_cnt_range, i_clk, i_rst_n, r_busy,
        (r_cnt != '0) && (r_cnt <= CSU_SQRT_STEPS))

endmodule

// File: sv/spectral_peak_frequency_estimator_top.sv
// ----------------------------------------------------------------------------
// spectral_peak_frequency_estimator_top
// Peak bin search over a real FFT spectrum with parabolic refinement to Hz.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the bins of one spectrum on the input channel, bin 0 first, with
//   i_last_bin set on bin N/2. For each bin beat one shared
//   multiplier squares the real part, then the imaginary part; the compare
//   against the running peak runs while the next bin is taken.
//   After the last bin the block stalls its input while
//   three 32-step square roots and a 17-step division run one after another
//   on a single compare-subtract unit, then one multiply scales the peak
//   position to Hz. A zero denominator or a saturating quotient skips the division.
//   The result beat sits in an output register; the input side is open
//   again as soon as the result is loaded there. If the receiver stalls, the
//   result holds and the next spectrum's result waits in its final step.
//   Configuration writes are taken at any edge with i_cfg_we high and are
//   meant to happen while no spectrum is in progress.
//   Reset clears the spectrum state, the last valid frequency and the
//   output valid flag, and loads the register reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectral_peak_frequency_estimator_top import spfe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [BW_W-1:0]         i_cfg_data,
    // bin input
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [BIN_W-1:0] i_bin_real,
    input  logic signed [BIN_W-1:0] i_bin_imag,
    input  logic                    i_last_bin,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [FREQ_W-1:0]       o_frequency,
    output logic [BIDX_W-1:0]       o_peak_bin,
    output logic [BIN_W-1:0]        o_peak_magnitude,
    output logic                    o_held
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SQ2      = 4'd1;
    localparam logic [3:0] S_RT_GO    = 4'd2;
    localparam logic [3:0] S_RT_WAIT  = 4'd3;
    localparam logic [3:0] S_DIFF     = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_POS      = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    // configuration
    logic [BW_W-1:0]   r_bin_width;
    logic [FREQ_W-1:0] r_low_limit;
    logic [FREQ_W-1:0] r_high_limit;

    // sequencer and bin pipeline
    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [BIN_W-1:0]  r_im_abs;
    logic              r_last_in;
    logic [PWR_W-1:0]  r_sq_acc;
    logic [PWR_W-1:0]  r_power;
    logic              r_pend;
    logic              r_pend_last;

    // spectrum state
    logic [CNT_W-1:0]  r_bin_cnt;
    logic [PWR_W-1:0]  r_prev_pwr;
    logic [PWR_W-1:0]  r_best_pwr;
    logic [BIDX_W-1:0] r_best_idx;
    logic [PWR_W-1:0]  r_left_pwr;
    logic [PWR_W-1:0]  r_right_pwr;
    logic              r_right_pend;
    logic [FREQ_W-1:0] r_last_valid;

    // refinement
    logic [1:0]          r_rt_sel;
    logic [MAG_W-1:0]    r_mag_l;
    logic [MAG_W-1:0]    r_mag_m;
    logic [MAG_W-1:0]    r_mag_r;
    logic signed [32:0]  r_num;
    logic signed [34:0]  r_den;
    logic                r_neg;
    logic [Q_W-1:0]      r_quot;
    logic [POS_W-1:0]    r_pos;
    logic [PROD_W-1:0]   r_prod;

    // output register
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_freq;
    logic [BIDX_W-1:0] r_out_bin;
    logic [BIN_W-1:0]  r_out_mag;
    logic              r_out_held;

    logic                 w_ready;
    logic                 w_in_acc;
    logic                 w_out_load;
    logic [BIN_W-1:0]     w_re_abs;
    logic [POS_W-1:0]     w_mul_a;
    logic [BW_W-1:0]      w_mul_b;
    logic [PROD_W-1:0]    w_mul_p;
    logic                 w_take;
    logic [32:0]          w_num_abs;
    logic [CSU_DIV_W-1:0] w_den_abs;
    logic                 w_den_zero;
    logic                 w_q_sat;
    logic [PWR_W-1:0]     w_rt_src;
    logic [POS_W-1:0]     w_pos_base;
    logic [27:0]          w_freq_raw;
    logic [FREQ_W-1:0]    w_freq;
    logic                 w_out_band;
    t_csu_cmd             w_cmd;
    t_csu_rsp             w_rsp;

    // hold input whenever the sequencer is not idle and while the last bin is being folded in
    assign w_ready    = (r_state == S_IDLE) && !(r_pend && r_pend_last);
    assign o_in_stall = !w_ready;
    assign w_in_acc   = i_in_valid && w_ready;
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign w_re_abs = i_bin_real[BIN_W-1] ? (BIN_W'(0) - $unsigned(i_bin_real))
                                          : $unsigned(i_bin_real);

    // one shared multiplier: squares per bin, position scaling at the end
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_mul_a = {4'b0, w_re_abs};
                w_mul_b = w_re_abs;
            end
            S_SQ2: begin
                w_mul_a = {4'b0, r_im_abs};
                w_mul_b = r_im_abs;
            end
            default: begin
                w_mul_a = r_pos;
                w_mul_b = r_bin_width;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_take = !r_pend_last && (r_bin_cnt >= CNT_W'(1)) && (r_bin_cnt <= HALF_LAST)
                    && ((r_bin_cnt == CNT_W'(1)) || (r_power > r_best_pwr));

    always_comb begin
        case (r_rt_sel)
            2'd0:    w_rt_src = r_left_pwr;
            2'd1:    w_rt_src = r_best_pwr;
            default: w_rt_src = r_right_pwr;
        endcase
    end

    assign w_num_abs  = r_num[32] ? 33'(-r_num) : 33'(r_num);
    assign w_den_abs  = r_den[34] ? CSU_DIV_W'(-r_den) : CSU_DIV_W'(r_den);
    assign w_den_zero = (r_den == '0);
    // quotient would reach 2^17 or more: clamp without dividing
    assign w_q_sat    = {3'b0, w_num_abs} >= {w_den_abs, 2'b00};

    always_comb begin
        w_cmd = '0;
        if (r_state == S_RT_GO) begin
            w_cmd.start = 1'b1;
            w_cmd.src   = {w_rt_src, 16'b0};
        end else if ((r_state == S_DIV) && !w_den_zero && !w_q_sat) begin
            w_cmd.start    = 1'b1;
            w_cmd.div_mode = 1'b1;
            w_cmd.rem_init = {5'b0, w_num_abs[32:2]};
            w_cmd.src      = {w_num_abs[1:0], 62'b0};
            w_cmd.divisor  = w_den_abs;
        end
    end

    spfe_csu u_csu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    assign w_pos_base = {r_best_idx, 16'b0, 1'b0} >> 1;
    assign w_freq_raw = r_prod[PROD_W-1:24];
    assign w_freq     = (w_freq_raw[27:20] != '0) ? '1 : w_freq_raw[FREQ_W-1:0];
    assign w_out_band = (w_freq > r_high_limit) || (w_freq < r_low_limit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (r_pend && r_pend_last) begin
                    n_state = S_RT_GO;
                end else if (w_in_acc) begin
                    n_state = S_SQ2;
                end
            end
            S_SQ2:     n_state = S_IDLE;
            S_RT_GO:   n_state = S_RT_WAIT;
            S_RT_WAIT: begin
                if (w_rsp.done) begin
                    n_state = (r_rt_sel == 2'd2) ? S_DIFF : S_RT_GO;
                end
            end
            S_DIFF:    n_state = S_DIV;
            S_DIV:     n_state = (w_den_zero || w_q_sat) ? S_POS : S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_rsp.done) begin
                    n_state = S_POS;
                end
            end
            S_POS:     n_state = S_MUL;
            S_MUL:     n_state = S_FIN;
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bin_width  <= RST_BIN_WIDTH;
            r_low_limit  <= RST_LOW_LIMIT;
            r_high_limit <= RST_HIGH_LIMIT;
            r_pend       <= 1'b0;
            r_pend_last  <= 1'b0;
            r_bin_cnt    <= '0;
            r_prev_pwr   <= '0;
            r_best_pwr   <= '0;
            r_best_idx   <= BIDX_W'(1);
            r_left_pwr   <= '0;
            r_right_pwr  <= '0;
            r_right_pend <= 1'b0;
            r_last_valid <= '0;
            r_rt_sel     <= '0;
            r_quot       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIN_WIDTH:  r_bin_width  <= i_cfg_data;
                    CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data[FREQ_W-1:0];
                    CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data[FREQ_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    // fold the previous bin's power into the peak search
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        if (w_take) begin
                            r_best_pwr   <= r_power;
                            r_best_idx   <= r_bin_cnt[BIDX_W-1:0];
                            r_left_pwr   <= r_prev_pwr;
                            r_right_pend <= 1'b1;
                        end else if (r_right_pend) begin
                            r_right_pwr  <= r_power;
                            r_right_pend <= 1'b0;
                        end
                        r_prev_pwr <= r_power;
                        if (r_bin_cnt != CNT_MAX) begin
                            r_bin_cnt <= r_bin_cnt + 1'b1;
                        end
                    end
                    if (w_in_acc) begin
                        r_sq_acc  <= w_mul_p[PWR_W-1:0];
                        r_im_abs  <= i_bin_imag[BIN_W-1] ?
                                     (BIN_W'(0) - $unsigned(i_bin_imag)) : $unsigned(i_bin_imag);
                        r_last_in <= i_last_bin;
                    end
                    r_rt_sel <= '0;
                end
                S_SQ2: begin
                    r_power     <= r_sq_acc + w_mul_p[PWR_W-1:0];
                    r_pend      <= 1'b1;
                    r_pend_last <= r_last_in;
                end
                S_RT_WAIT: begin
                    if (w_rsp.done) begin
                        case (r_rt_sel)
                            2'd0:    r_mag_l <= w_rsp.result;
                            2'd1:    r_mag_m <= w_rsp.result;
                            default: r_mag_r <= w_rsp.result;
                        endcase
                        r_rt_sel <= r_rt_sel + 1'b1;
                    end
                end
                S_DIFF: begin
                    r_num <= $signed({1'b0, r_mag_l}) - $signed({1'b0, r_mag_r});
                    r_den <= $signed({3'b0, r_mag_l}) + $signed({3'b0, r_mag_r})
                             - $signed({2'b0, r_mag_m, 1'b0});
                end
                S_DIV: begin
                    r_neg <= (r_num[32] != r_den[34]);
                    if (w_den_zero) begin
                        r_quot <= '0;
                    end else if (w_q_sat) begin
                        r_quot <= Q_MAX;
                    end
                end
                S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        r_quot <= (w_rsp.result[Q_W-1:0] > Q_MAX) ? Q_MAX
                                                                   : w_rsp.result[Q_W-1:0];
                    end
                end
                S_POS: begin
                    r_pos <= r_neg ? (w_pos_base - POS_W'(r_quot))
                                   : (w_pos_base + POS_W'(r_quot));
                end
                S_MUL: begin
                    r_prod <= w_mul_p;
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_out_bin   <= r_best_idx;
                        r_out_mag   <= r_mag_m[MAG_W-1:8];
                        r_out_held  <= w_out_band;
                        r_out_freq  <= w_out_band ? r_last_valid : w_freq;
                        if (!w_out_band) begin
                            r_last_valid <= w_freq;
                        end
                        // drop the spectrum, keep the last valid frequency
                        r_pend_last  <= 1'b0;
                        r_bin_cnt    <= '0;
                        r_prev_pwr   <= '0;
                        r_best_pwr   <= '0;
                        r_best_idx   <= BIDX_W'(1);
                        r_left_pwr   <= '0;
                        r_right_pwr  <= '0;
                        r_right_pend <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frequency      = r_out_freq;
    assign o_peak_bin       = r_out_bin;
    assign o_peak_magnitude = r_out_mag;
    assign o_held           = r_out_held;

    `ASSERT_ALWAYS(a_best_idx_nonzero, i_clk, i_rst_n, r_best_idx != '0)
    `ASSERT_ALWAYS(a_quot_clamped, i_clk, i_rst_n, r_quot <= Q_MAX)
    `ASSERT_NEXT(a_accept_to_square, i_clk, i_rst_n, w_in_acc, r_state == S_SQ2)
    `ASSERT_NEXT(a_fin_waits_on_stall, i_clk, i_rst_n,
        (r_state == S_FIN) && r_out_valid && i_out_stall, r_state == S_FIN)

endmodule
